### hw/rtl/sacl_pkg.sv
// Shared types, constants and helper functions for the set-associative cache lookup core.
// Used by sacl_front, sacl_back and the top level; depends on nothing else.
`default_nettype none

package sacl_pkg;

    localparam int MAX_SETS_DEF = 256;
    localparam int MAX_WAYS_DEF = 8;
    localparam int QUEUE_DEPTH  = 2;

    localparam int ADDR_W      = 32;
    localparam int TAG_W       = 32;
    localparam int COUNT_W     = 32;
    localparam int WAY_OUT_W   = 3;
    localparam int SET_OUT_W   = 8;
    localparam int LFSR_W      = 16;
    localparam int OUT_DATA_W  = 80;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LFSR_SEED      = 2'd3;

    localparam logic [3:0]        SET_COUNT_LOG2_RST = 4'd0;
    localparam logic [1:0]        WAYS_LOG2_RST      = 2'd0;
    localparam logic [3:0]        OFFSET_BITS_RST    = 4'd2;
    localparam logic [LFSR_W-1:0] LFSR_SEED_RST      = 16'd44257;
    localparam logic [3:0]        OFFSET_BITS_MAX    = 4'd8;
    localparam logic [LFSR_W-1:0] LFSR_TAPS          = 16'hB400;

    typedef struct packed {
        logic [3:0]        set_count_log2;
        logic [1:0]        ways_log2;
        logic [3:0]        offset_bits;
        logic              seed_load;
        logic [LFSR_W-1:0] seed;
    } cfg_t;

    function automatic logic [LFSR_W-1:0] seed_value(input logic [LFSR_W-1:0] s);
        seed_value = (s == '0) ? LFSR_W'(1) : s;
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] sh;
        sh = v >> 1;
        lfsr_next = v[0] ? (sh ^ LFSR_TAPS) : sh;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sacl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the per-way tag stores and the fill-level store.
`default_nettype none

module sacl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                       aclk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/sacl_front.sv
// Front end: accepts access words and splits each address into set and tag.
// Depends on sacl_pkg; feeds the lookup queue.
`default_nettype none

module sacl_front
    import sacl_pkg::*;
#(
    parameter int MAX_SETS = MAX_SETS_DEF
) (
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [ADDR_W-1:0]    s_axis_tdata,
    input  wire cfg_t                 cfg,
    input  wire logic                 clear_done,
    input  wire logic                 q_full,
    output logic                      q_push,
    output logic [TAG_W+((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] q_wdata
);

    localparam int SET_AW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SBITS_MAX = $clog2(MAX_SETS + 1) - 1;

    logic [3:0]        sbits;
    logic [3:0]        obits;
    logic [ADDR_W-1:0] block;
    logic [ADDR_W-1:0] set_wide;
    logic [TAG_W-1:0]  tag;

    always_comb begin
        sbits = (cfg.set_count_log2 > 4'(SBITS_MAX)) ? 4'(SBITS_MAX) : cfg.set_count_log2;
        obits = (cfg.offset_bits > OFFSET_BITS_MAX) ? OFFSET_BITS_MAX : cfg.offset_bits;
        block    = s_axis_tdata >> obits;
        set_wide = block & ((ADDR_W'(1) << sbits) - ADDR_W'(1));
        tag      = TAG_W'(block >> sbits);
    end

    assign s_axis_tready = clear_done && !q_full;
    assign q_push        = s_axis_tvalid && s_axis_tready;
    assign q_wdata       = {tag, set_wide[SET_AW-1:0]};

endmodule

`default_nettype wire

### hw/rtl/sacl_queue.sv
// Short first-in first-out queue that decouples the front end from the lookup engine.
// Standalone; payload width and depth are parameters.
`default_nettype none

module sacl_queue #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty,
    output logic                  full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

### hw/rtl/sacl_back.sv
// Lookup engine: reads a set from the way and fill memories, compares tags, updates state
// and counters, and holds the result word. Depends on sacl_pkg and sacl_ram.
`default_nettype none

module sacl_back
    import sacl_pkg::*;
#(
    parameter int MAX_SETS = MAX_SETS_DEF,
    parameter int MAX_WAYS = MAX_WAYS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cfg_t                   cfg,
    input  wire logic [TAG_W+((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] q_rdata,
    input  wire logic                   q_empty,
    output logic                        q_pop,
    output logic                        clear_done,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        out_hit,
    output logic [WAY_OUT_W-1:0]        out_way,
    output logic                        out_evicted,
    output logic [SET_OUT_W-1:0]        out_set,
    output logic [COUNT_W-1:0]          out_hit_count,
    output logic [COUNT_W-1:0]          out_miss_count
);

    localparam int SET_AW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WBITS_MAX = $clog2(MAX_WAYS + 1) - 1;
    localparam int WAYS_PHYS = 1 << WBITS_MAX;
    localparam int WAY_W     = (WAYS_PHYS > 1) ? $clog2(WAYS_PHYS) : 1;
    localparam int FILL_W    = $clog2(WAYS_PHYS + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [SET_AW-1:0]  clr_reg, clr_next;
    logic [SET_AW-1:0]  set_reg, set_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [LFSR_W-1:0]  lfsr_reg, lfsr_next_val;
    logic [COUNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0] miss_cnt_reg, miss_cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic               hit_reg, evicted_reg;
    logic [WAY_W-1:0]   way_reg;
    logic [SET_AW-1:0]  oset_reg;

    logic [TAG_W-1:0]   tag_rd [WAYS_PHYS];
    logic [FILL_W-1:0]  fill_rd;
    logic [WAYS_PHYS-1:0] match;
    logic [WAYS_PHYS-1:0] tag_we;

    logic [1:0]         wl;
    logic [FILL_W-1:0]  ways_n;
    logic [FILL_W-1:0]  ways_mask;
    logic [FILL_W-1:0]  valid_n;
    logic               look;
    logic               hit;
    logic               full_set;
    logic [WAY_W-1:0]   hit_way;
    logic [WAY_W-1:0]   way_sel;
    logic [LFSR_W-1:0]  lfsr_step;
    logic               fill_we;
    logic [SET_AW-1:0]  fill_waddr;
    logic [FILL_W-1:0]  fill_wdata;

    logic [SET_AW+SET_OUT_W-1:0] set_ext;
    logic [WAY_W+WAY_OUT_W-1:0]  way_ext;

    genvar g;
    generate
        for (g = 0; g < WAYS_PHYS; g++) begin : g_way
            sacl_ram #(
                .WIDTH (TAG_W),
                .DEPTH (MAX_SETS)
            ) u_tag_ram (
                .aclk  (aclk),
                .we    (tag_we[g]),
                .waddr (set_reg),
                .wdata (tag_reg),
                .raddr (q_rdata[SET_AW-1:0]),
                .rdata (tag_rd[g])
            );
        end
    endgenerate

    sacl_ram #(
        .WIDTH (FILL_W),
        .DEPTH (MAX_SETS)
    ) u_fill_ram (
        .aclk  (aclk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (q_rdata[SET_AW-1:0]),
        .rdata (fill_rd)
    );

    always_comb begin
        look      = (state_reg == ST_LOOK);
        wl        = (int'(cfg.ways_log2) > WBITS_MAX) ? 2'(WBITS_MAX) : cfg.ways_log2;
        ways_n    = FILL_W'(1) << wl;
        ways_mask = ways_n - FILL_W'(1);
        valid_n   = (fill_rd < ways_n) ? fill_rd : ways_n;
        full_set  = (fill_rd >= ways_n);

        for (int w = 0; w < WAYS_PHYS; w++) begin
            match[w] = (FILL_W'(w) < valid_n) && (tag_rd[w] == tag_reg);
        end
        hit     = |match;
        hit_way = '0;
        for (int w = WAYS_PHYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
        end

        lfsr_step = lfsr_next(lfsr_reg);
        if (hit) begin
            way_sel = hit_way;
        end else if (!full_set) begin
            way_sel = fill_rd[WAY_W-1:0];
        end else begin
            way_sel = lfsr_step[WAY_W-1:0] & ways_mask[WAY_W-1:0];
        end

        for (int w = 0; w < WAYS_PHYS; w++) begin
            tag_we[w] = look && !hit && (way_sel == WAY_W'(w));
        end

        if (state_reg == ST_CLEAR) begin
            fill_we    = 1'b1;
            fill_waddr = clr_reg;
            fill_wdata = '0;
        end else begin
            fill_we    = look && !hit && !full_set;
            fill_waddr = set_reg;
            fill_wdata = fill_rd + FILL_W'(1);
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        set_next      = set_reg;
        tag_next      = tag_reg;
        lfsr_next_val = lfsr_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        q_pop         = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + SET_AW'(1);
                if (clr_reg == SET_AW'(MAX_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_empty && (!m_valid_reg || m_ready)) begin
                    q_pop      = 1'b1;
                    set_next   = q_rdata[SET_AW-1:0];
                    tag_next   = q_rdata[TAG_W+SET_AW-1:SET_AW];
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                m_valid_next = 1'b1;
                if (hit) begin
                    hit_cnt_next = (&hit_cnt_reg) ? hit_cnt_reg : hit_cnt_reg + COUNT_W'(1);
                end else begin
                    miss_cnt_next = (&miss_cnt_reg) ? miss_cnt_reg
                                                    : miss_cnt_reg + COUNT_W'(1);
                    if (full_set) begin
                        lfsr_next_val = lfsr_step;
                    end
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg.seed_load) begin
            lfsr_next_val = seed_value(cfg.seed);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            lfsr_reg     <= seed_value(LFSR_SEED_RST);
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            lfsr_reg     <= lfsr_next_val;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        set_reg <= set_next;
        tag_reg <= tag_next;
        if (look) begin
            hit_reg     <= hit;
            evicted_reg <= !hit && full_set;
            way_reg     <= way_sel;
            oset_reg    <= set_reg;
        end
    end

    assign set_ext = {{SET_OUT_W{1'b0}}, oset_reg};
    assign way_ext = {{WAY_OUT_W{1'b0}}, way_reg};

    assign clear_done     = (state_reg != ST_CLEAR);
    assign m_valid        = m_valid_reg;
    assign out_hit        = hit_reg;
    assign out_way        = way_ext[WAY_OUT_W-1:0];
    assign out_evicted    = evicted_reg;
    assign out_set        = set_ext[SET_OUT_W-1:0];
    assign out_hit_count  = hit_cnt_reg;
    assign out_miss_count = miss_cnt_reg;

endmodule

`default_nettype wire

### hw/rtl/set_associative_cache_lookup_core.sv
// An accepted input word is written into the queue, then popped into the lookup engine
// while the per-way tag memories and the fill-level memory are read; the compare result is
// registered with m_axis_tvalid. The engine takes no new word until the current one has
// finished its read-compare-write; these memories share one read and one write per set.
// Reset: after aresetn the fill-level memory is cleared over MAX_SETS cycles, during which
// s_axis_tready stays low; configuration writes are taken throughout.
`default_nettype none

module set_associative_cache_lookup_core
    import sacl_pkg::*;
#(
    parameter int MAX_SETS = MAX_SETS_DEF,
    parameter int MAX_WAYS = MAX_WAYS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // address[31:0]
    input  wire logic [ADDR_W-1:0]     s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // hit[0], way[3:1], evicted[4], set_index[12:5], hit_count[44:13],
    // miss_count[76:45], zero[79:77]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int Q_W    = TAG_W + SET_AW;

    logic [3:0]        set_count_log2_reg;
    logic [1:0]        ways_log2_reg;
    logic [3:0]        offset_bits_reg;
    cfg_t              cfg;

    logic              q_push, q_pop, q_empty, q_full, clear_done;
    logic [Q_W-1:0]    q_wdata, q_rdata;

    logic                 out_hit, out_evicted;
    logic [WAY_OUT_W-1:0] out_way;
    logic [SET_OUT_W-1:0] out_set;
    logic [COUNT_W-1:0]   out_hit_count, out_miss_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_count_log2_reg <= SET_COUNT_LOG2_RST;
            ways_log2_reg      <= WAYS_LOG2_RST;
            offset_bits_reg    <= OFFSET_BITS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_SET_COUNT_LOG2: set_count_log2_reg <= cfg_wr_data[3:0];
                REG_WAYS_LOG2:      ways_log2_reg      <= cfg_wr_data[1:0];
                REG_OFFSET_BITS:    offset_bits_reg    <= cfg_wr_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.set_count_log2 = set_count_log2_reg;
        cfg.ways_log2      = ways_log2_reg;
        cfg.offset_bits    = offset_bits_reg;
        cfg.seed_load      = cfg_wr_en && (cfg_wr_index == REG_LFSR_SEED);
        cfg.seed           = cfg_wr_data[LFSR_W-1:0];
    end

    sacl_front #(
        .MAX_SETS (MAX_SETS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg           (cfg),
        .clear_done    (clear_done),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    sacl_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty),
        .full    (q_full)
    );

    sacl_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .q_rdata        (q_rdata),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .clear_done     (clear_done),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .out_hit        (out_hit),
        .out_way        (out_way),
        .out_evicted    (out_evicted),
        .out_set        (out_set),
        .out_hit_count  (out_hit_count),
        .out_miss_count (out_miss_count)
    );

    assign m_axis_tdata = {3'b000, out_miss_count, out_hit_count, out_set,
                           out_evicted, out_way, out_hit};

endmodule

`default_nettype wire

### tb/sv/set_associative_cache_lookup_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for set_associative_cache_lookup_core: a queue-fed driver sends
// address words and a monitor checks every result word against a built-in cache predictor.
// Depends on sacl_pkg and the core RTL only.

module set_associative_cache_lookup_core_tb;
    import sacl_pkg::*;

    typedef struct packed {
        logic               hit;
        logic [2:0]         way;
        logic               evicted;
        logic [7:0]         set_index;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
    } lookup_result_t;

    localparam int unsigned WATCHDOG_LIMIT = 5000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [ADDR_W-1:0]     s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Predictor state: tags, fill levels, victim generator, counters and registers.
    logic [TAG_W-1:0]   tag_mem [MAX_SETS_DEF*MAX_WAYS_DEF];
    int unsigned        line_fill [MAX_SETS_DEF];
    logic [LFSR_W-1:0]  victim_lfsr;
    logic [COUNT_W-1:0] hits_so_far;
    logic [COUNT_W-1:0] misses_so_far;
    logic [3:0]         sets_log2_reg;
    logic [1:0]         ways_log2_reg;
    logic [3:0]         offset_reg;

    logic [ADDR_W-1:0]  pending_addrs [$];
    lookup_result_t     expected_lookups [$];
    lookup_result_t     seen_result;
    lookup_result_t     due_result;
    logic               idling_on = 1'b1;
    int unsigned        send_hold = 0;
    int unsigned        sink_hold = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        mismatch_count = 0;

    set_associative_cache_lookup_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned eff_set_bits();
        int unsigned n;
        n = sets_log2_reg;
        while (n > 0 && (1 << n) > MAX_SETS_DEF)
            n--;
        return n;
    endfunction

    function automatic int unsigned eff_offset();
        return (offset_reg > OFFSET_BITS_MAX) ? OFFSET_BITS_MAX : offset_reg;
    endfunction

    function automatic int unsigned eff_ways();
        int unsigned n;
        n = ways_log2_reg;
        while (n > 0 && (1 << n) > MAX_WAYS_DEF)
            n--;
        return 1 << n;
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
        lookup_result_t r;
        int unsigned    sbits, ways, set_no, filled, live, w;
        logic [ADDR_W-1:0] blk, tag;
        sbits = eff_set_bits();
        ways = eff_ways();
        blk = addr >> eff_offset();
        set_no = blk & ((32'd1 << sbits) - 1);
        tag = blk >> sbits;
        filled = line_fill[set_no];
        live = (filled < ways) ? filled : ways;
        r = '0;
        r.set_index = set_no[7:0];
        for (w = 0; w < live && !r.hit; w++) begin
            if (tag_mem[set_no*MAX_WAYS_DEF + w] == tag) begin
                r.hit = 1'b1;
                r.way = w[2:0];
            end
        end
        if (r.hit) begin
            if (hits_so_far != '1)
                hits_so_far++;
        end else begin
            if (misses_so_far != '1)
                misses_so_far++;
            if (filled < ways) begin
                r.way = filled[2:0];
                line_fill[set_no] = filled + 1;
            end else begin
                victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_TAPS)
                                             : (victim_lfsr >> 1);
                r.way = victim_lfsr[2:0] & 3'(ways - 1);
                r.evicted = 1'b1;
            end
            tag_mem[set_no*MAX_WAYS_DEF + r.way] = tag;
        end
        r.hit_count = hits_so_far;
        r.miss_count = misses_so_far;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] data;
        data = value[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        case (idx)
            REG_SET_COUNT_LOG2: sets_log2_reg = data[3:0];
            REG_WAYS_LOG2:      ways_log2_reg = data[1:0];
            REG_OFFSET_BITS:    offset_reg = data[3:0];
            REG_LFSR_SEED:      victim_lfsr = (data == '0) ? 16'd1 : data;
            default: ;
        endcase
    endtask

    // Upper data bits above each register's width are filled at random; the core ignores them.
    task automatic set_geometry(input int unsigned sets, input int unsigned ways,
                                input int unsigned offset, input int unsigned seed);
        write_reg(REG_SET_COUNT_LOG2, ($urandom & 32'hFFF0) | sets);
        write_reg(REG_WAYS_LOG2, ($urandom & 32'hFFFC) | ways);
        write_reg(REG_OFFSET_BITS, ($urandom & 32'hFFF0) | offset);
        write_reg(REG_LFSR_SEED, seed);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending_addrs.size() != 0 || s_axis_tvalid || expected_lookups.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Most addresses come from a small pool of lines crowded into a few sets, so that
    // hits, fills and evictions all occur; the rest are fully random.
    task automatic run_phase(input int unsigned n_items);
        logic [ADDR_W-1:0] pool [$];
        logic [ADDR_W-1:0] a, set_mask, line_mask, hot_base;
        int unsigned       obits, hot_sets, pool_n, k;
        obits = eff_offset();
        set_mask = (32'd1 << eff_set_bits()) - 1;
        line_mask = (32'd1 << obits) - 1;
        hot_sets = $urandom_range(1, 4);
        hot_base = $urandom;
        pool_n = eff_ways() * hot_sets + $urandom_range(1, 6);
        for (k = 0; k < pool_n; k++) begin
            a = $urandom;
            a = (a & ~(set_mask << obits))
                | (((hot_base + $urandom_range(0, hot_sets - 1)) & set_mask) << obits);
            pool.insert(pool.size(), a);
        end
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 9) < 8) begin
                a = pool[$urandom_range(0, pool.size() - 1)];
                a = (a & ~line_mask) | ($urandom & line_mask);
            end else begin
                a = $urandom;
            end
            pending_addrs.insert(pending_addrs.size(), a);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_lookups.insert(expected_lookups.size(),
                                        predict_lookup(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_hold != 0) begin
                    send_hold--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_addrs.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_addrs.pop_front();
                    if (idling_on && $urandom_range(0, 9) == 0)
                        send_hold = $urandom_range(1, 18);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_result.hit = m_axis_tdata[0];
                seen_result.way = m_axis_tdata[3:1];
                seen_result.evicted = m_axis_tdata[4];
                seen_result.set_index = m_axis_tdata[12:5];
                seen_result.hit_count = m_axis_tdata[44:13];
                seen_result.miss_count = m_axis_tdata[76:45];
                if (expected_lookups.size() == 0) begin
                    report_mismatch("result word with no access pending",
                                    m_axis_tdata[63:0], '0);
                end else begin
                    due_result = expected_lookups.pop_front();
                    if (seen_result.hit !== due_result.hit)
                        report_mismatch("hit", seen_result.hit, due_result.hit);
                    if (seen_result.way !== due_result.way)
                        report_mismatch("way", seen_result.way, due_result.way);
                    if (seen_result.evicted !== due_result.evicted)
                        report_mismatch("evicted", seen_result.evicted, due_result.evicted);
                    if (seen_result.set_index !== due_result.set_index)
                        report_mismatch("set_index", seen_result.set_index,
                                        due_result.set_index);
                    if (seen_result.hit_count !== due_result.hit_count)
                        report_mismatch("hit_count", seen_result.hit_count,
                                        due_result.hit_count);
                    if (seen_result.miss_count !== due_result.miss_count)
                        report_mismatch("miss_count", seen_result.miss_count,
                                        due_result.miss_count);
                end
            end
            if (sink_hold != 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idling_on && $urandom_range(0, 11) == 0)
                    sink_hold = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned i, p;
        for (i = 0; i < MAX_SETS_DEF; i++)
            line_fill[i] = 0;
        sets_log2_reg = SET_COUNT_LOG2_RST;
        ways_log2_reg = WAYS_LOG2_RST;
        offset_reg = OFFSET_BITS_RST;
        victim_lfsr = LFSR_SEED_RST;
        hits_so_far = '0;
        misses_so_far = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: one set, one way, so every new line evicts the previous one.
        pending_addrs.insert(pending_addrs.size(), 32'h0000_0000);
        pending_addrs.insert(pending_addrs.size(), 32'hFFFF_FFFF);
        pending_addrs.insert(pending_addrs.size(), 32'h0000_0000);
        pending_addrs.insert(pending_addrs.size(), 32'h0000_0003);
        drain();

        // Oversized set count and offset are clamped; a zero seed starts the generator at one.
        set_geometry(15, 3, 15, 0);
        pending_addrs.insert(pending_addrs.size(), 32'h0000_0000);
        pending_addrs.insert(pending_addrs.size(), 32'hFFFF_FFFF);
        pending_addrs.insert(pending_addrs.size(), 32'h0000_00FF);
        pending_addrs.insert(pending_addrs.size(), 32'h0000_0100);
        pending_addrs.insert(pending_addrs.size(), 32'hFFFF_FF00);
        pending_addrs.insert(pending_addrs.size(), 32'h0001_0000);
        pending_addrs.insert(pending_addrs.size(), 32'h0002_00AB);
        drain();

        // Shrinking and regrowing the way count leaves the same tag in two ways of a set.
        set_geometry(0, 1, 0, 16'hFFFF);
        pending_addrs.insert(pending_addrs.size(), 32'h0000_0010);
        pending_addrs.insert(pending_addrs.size(), 32'h0000_0020);
        drain();
        set_geometry(0, 0, 0, 16'hFFFF);
        pending_addrs.insert(pending_addrs.size(), 32'h0000_0020);
        drain();
        set_geometry(0, 1, 0, 16'hFFFF);
        pending_addrs.insert(pending_addrs.size(), 32'h0000_0020);
        pending_addrs.insert(pending_addrs.size(), 32'h0000_0010);

        for (p = 0; p < 12; p++) begin
            drain();
            idling_on = (p != 11) && ($urandom_range(0, 3) != 0);
            case (p)
                0: set_geometry(8, 3, 8, $urandom_range(1, 65535));
                1: set_geometry(0, 0, 0, 0);
                2: set_geometry(15, 3, 0, 65535);
                3: set_geometry(3, 2, 15, 1);
                default: set_geometry($urandom_range(0, 15), $urandom_range(0, 3),
                                      $urandom_range(0, 15),
                                      ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 65535));
            endcase
            run_phase(95);
        end
        drain();

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_ram.sv
hw/rtl/sacl_front.sv
hw/rtl/sacl_queue.sv
hw/rtl/sacl_back.sv
hw/rtl/set_associative_cache_lookup_core.sv
tb/sv/set_associative_cache_lookup_core_tb.sv
